// ===== sv/i2cme_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
package i2cme_pkg;

    localparam int PHASE_W = 4;
    localparam int BIT_W = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_A = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_B = 4'd2;
    localparam logic [PHASE_W-1:0] PH_STOP_A  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_B  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_C  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WR_ACK  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RD_ACK  = 4'd11;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_out;

    typedef struct packed {
        logic [PHASE_W-1:0] entry;
        logic [7:0]         tx_byte;
        logic               send_ack;
        logic               sda_in;
    } t_op;

endpackage

// ===== sv/i2cme_front.sv =====
// Front end: accepts requests and classifies each mode into its entry phase.
module i2cme_front (
    input  logic              i_in_valid,
    input  i2cme_pkg::t_in    i_in_data,
    input  logic              i_full,
    output logic              o_in_stall,
    output logic              o_push,
    output i2cme_pkg::t_op    o_op
);

    logic [i2cme_pkg::PHASE_W-1:0] w_entry;

    always_comb begin
        case (i_in_data.mode)
            i2cme_pkg::MODE_START: w_entry = i2cme_pkg::PH_START_A;
            i2cme_pkg::MODE_STOP:  w_entry = i2cme_pkg::PH_STOP_A;
            i2cme_pkg::MODE_WRITE: w_entry = i2cme_pkg::PH_WR_HIGH;
            i2cme_pkg::MODE_READ:  w_entry = i2cme_pkg::PH_RD_HIGH;
            default:               w_entry = i2cme_pkg::PH_IDLE;
        endcase
    end

    assign o_in_stall       = i_full;
    assign o_push           = i_in_valid && !i_full;
    assign o_op.entry       = w_entry;
    assign o_op.tx_byte     = i_in_data.tx_byte;
    assign o_op.send_ack    = i_in_data.send_ack;
    assign o_op.sda_in      = i_in_data.sda_in;

endmodule

// ===== sv/i2cme_fifo.sv =====
// Short queue of classified requests between the front and back ends.
module i2cme_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cme_pkg::t_op    i_op,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output i2cme_pkg::t_op    o_op
);

    i2cme_pkg::t_op                r_mem [i2cme_pkg::FIFO_DEPTH];
    logic [i2cme_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [i2cme_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [i2cme_pkg::CNT_W-1:0]   r_count;
    logic [i2cme_pkg::CNT_W-1:0]   n_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_count == i2cme_pkg::CNT_W'(i2cme_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/i2cme_back.sv =====
// Back end: bus phase sequencer with a registered result stage.
module i2cme_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  i2cme_pkg::t_op    i_op,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_out_valid,
    output i2cme_pkg::t_out   o_out_data
);

    logic [i2cme_pkg::PHASE_W-1:0] r_phase;
    logic [i2cme_pkg::PHASE_W-1:0] n_phase;
    logic [i2cme_pkg::BIT_W-1:0]   r_bit_count;
    logic [i2cme_pkg::BIT_W-1:0]   n_bit_count;
    logic [7:0]                    r_send;
    logic [7:0]                    n_send;
    logic [7:0]                    r_recv;
    logic [7:0]                    n_recv;
    logic                          r_ack_choice;
    logic                          n_ack_choice;
    logic                          r_ack_flag;
    logic                          n_ack_flag;
    logic                          r_idle_scl;
    logic                          n_idle_scl;
    logic                          r_idle_sda;
    logic                          n_idle_sda;
    logic                          r_out_valid;
    i2cme_pkg::t_out               r_out;
    i2cme_pkg::t_out               n_out;
    logic                          w_pop;
    logic [i2cme_pkg::PHASE_W-1:0] w_ph;
    logic                          w_start;

    assign w_pop       = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_start     = (r_phase == i2cme_pkg::PH_IDLE);
    assign w_ph        = w_start ? i_op.entry : r_phase;

    always_comb begin
        n_bit_count  = r_bit_count;
        n_send       = r_send;
        n_recv       = r_recv;
        n_ack_choice = r_ack_choice;
        n_ack_flag   = r_ack_flag;
        n_idle_scl   = r_idle_scl;
        n_idle_sda   = r_idle_sda;
        if (w_start && (i_op.entry == i2cme_pkg::PH_WR_HIGH)) begin
            n_send      = i_op.tx_byte;
            n_bit_count = '0;
        end
        if (w_start && (i_op.entry == i2cme_pkg::PH_RD_HIGH)) begin
            n_ack_choice = i_op.send_ack;
            n_recv       = '0;
            n_bit_count  = '0;
        end
        n_phase = w_ph;
        n_out.scl_level = r_idle_scl;
        n_out.sda_level = r_idle_sda;
        n_out.busy_res  = 1'b1;
        n_out.done_res  = 1'b0;
        case (w_ph)
            i2cme_pkg::PH_START_A: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b1;
                n_phase = i2cme_pkg::PH_START_B;
            end
            i2cme_pkg::PH_START_B: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b0;
                n_out.done_res  = 1'b1;
                n_idle_scl = 1'b0;
                n_idle_sda = 1'b0;
                n_phase = i2cme_pkg::PH_IDLE;
            end
            i2cme_pkg::PH_STOP_A: begin
                n_out.scl_level = r_idle_scl;
                n_out.sda_level = 1'b0;
                n_phase = i2cme_pkg::PH_STOP_B;
            end
            i2cme_pkg::PH_STOP_B: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b0;
                n_phase = i2cme_pkg::PH_STOP_C;
            end
            i2cme_pkg::PH_STOP_C: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b1;
                n_out.done_res  = 1'b1;
                n_idle_scl = 1'b1;
                n_idle_sda = 1'b1;
                n_phase = i2cme_pkg::PH_IDLE;
            end
            i2cme_pkg::PH_WR_HIGH: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = n_send[7];
                n_phase = i2cme_pkg::PH_WR_LOW;
            end
            i2cme_pkg::PH_WR_LOW: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = r_send[7];
                n_send = {r_send[6:0], 1'b0};
                if (r_bit_count == i2cme_pkg::BIT_LAST) begin
                    n_bit_count = '0;
                    n_phase = i2cme_pkg::PH_WR_ACK;
                end else begin
                    n_bit_count = r_bit_count + 1'b1;
                    n_phase = i2cme_pkg::PH_WR_HIGH;
                end
            end
            i2cme_pkg::PH_WR_ACK: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b1;
                n_out.done_res  = 1'b1;
                n_ack_flag = !i_op.sda_in;
                n_idle_scl = 1'b0;
                n_idle_sda = 1'b1;
                n_phase = i2cme_pkg::PH_IDLE;
            end
            i2cme_pkg::PH_RD_HIGH: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b1;
                n_recv = {n_recv[6:0], i_op.sda_in};
                n_phase = i2cme_pkg::PH_RD_LOW;
            end
            i2cme_pkg::PH_RD_LOW: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = 1'b1;
                if (r_bit_count == i2cme_pkg::BIT_LAST) begin
                    n_bit_count = '0;
                    n_phase = i2cme_pkg::PH_RD_ACK;
                end else begin
                    n_bit_count = r_bit_count + 1'b1;
                    n_phase = i2cme_pkg::PH_RD_HIGH;
                end
            end
            i2cme_pkg::PH_RD_ACK: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = !r_ack_choice;
                n_out.done_res  = 1'b1;
                n_idle_scl = 1'b0;
                n_idle_sda = 1'b1;
                n_phase = i2cme_pkg::PH_IDLE;
            end
            default: begin
                n_out.busy_res = 1'b0;
                n_phase = i2cme_pkg::PH_IDLE;
            end
        endcase
        n_out.rx_byte  = n_recv;
        n_out.ack_seen = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cme_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_send       <= '0;
            r_recv       <= '0;
            r_ack_choice <= 1'b0;
            r_ack_flag   <= 1'b0;
            r_idle_scl   <= 1'b1;
            r_idle_sda   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_send       <= n_send;
                r_recv       <= n_recv;
                r_ack_choice <= n_ack_choice;
                r_ack_flag   <= n_ack_flag;
                r_idle_scl   <= n_idle_scl;
                r_idle_sda   <= n_idle_sda;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.busy_res)
        else $error("done result without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && n_out.done_res |=> r_phase == i2cme_pkg::PH_IDLE)
        else $error("sequencer not idle after last tick");

    a_bits_in_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count != '0 |-> (r_phase == i2cme_pkg::PH_WR_HIGH
            || r_phase == i2cme_pkg::PH_WR_LOW || r_phase == i2cme_pkg::PH_RD_HIGH
            || r_phase == i2cme_pkg::PH_RD_LOW))
        else $error("bit count outside a byte transfer");

endmodule

// ===== sv/i2c_master_byte_engine_unit.sv =====
// Top level of the I2C master byte engine.
// A request is written into the queue, and its result is registered in the result stage
// when the back end pops it.
// The engine takes one request per cycle while the output is not stalled.
// A four-entry request queue lets the input side run on while the output stalls.
// Reset is synchronous and active low; it empties the queue and the result stage,
// sets the sequencer idle and returns both bus lines to released.
module i2c_master_byte_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i2cme_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output i2cme_pkg::t_out   o_out_data
);

    logic           w_full;
    logic           w_empty;
    logic           w_push;
    logic           w_pop;
    i2cme_pkg::t_op w_push_op;
    i2cme_pkg::t_op w_head_op;

    i2cme_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    i2cme_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_op    (w_head_op)
    );

    i2cme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_op        (w_head_op),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
